### src/qcss_pkg.sv
// Package with the shared types, constants and segment decode of the encoder counter.
`timescale 1ns / 1ps

package qcss_pkg;

  // Field widths.
  localparam int COUNT_W   = 8;
  localparam int SEG_W     = 7;
  localparam int LOCKOUT_W = 8;
  localparam int DIGIT_W   = 4;

  // Default saturation limit of the count and reset value of the lockout register.
  localparam int COUNT_LIMIT_DEFAULT = 99;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 8'd50;
  localparam logic [LOCKOUT_W-1:0] ELAPSED_MAX   = 8'd255;

  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic [SEG_W-1:0]          seg_t;
  typedef logic [LOCKOUT_W-1:0]      ms_t;
  typedef logic [DIGIT_W-1:0]        digit_t;

  // Decoded display for one count.
  typedef struct packed {
    seg_t tens;
    seg_t units;
    logic minus;
  } disp_t;

  // Segment pattern of one decimal digit, bit 0 is segment a.
  function automatic seg_t digit_segments(input digit_t digit);
    seg_t seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h27;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h3F;
    endcase
    return seg;
  endfunction

endpackage

### src/qcss_if.sv
// Valid/ready channel interfaces for the encoder samples and the display results.
`timescale 1ns / 1ps

interface qcss_in_if;
  logic valid;
  logic ready;
  logic enc_a;
  logic enc_b;
  logic button_n;
  logic ms_tick;

  modport source (output valid, output enc_a, output enc_b, output button_n,
                  output ms_tick, input ready);
  modport sink   (input valid, input enc_a, input enc_b, input button_n,
                  input ms_tick, output ready);
endinterface

interface qcss_out_if;
  logic                  valid;
  logic                  ready;
  qcss_pkg::count_t      count;
  qcss_pkg::seg_t        tens_segments;
  qcss_pkg::seg_t        units_segments;
  logic                  minus_dot;

  modport source (output valid, output count, output tens_segments,
                  output units_segments, output minus_dot, input ready);
  modport sink   (input valid, input count, input tens_segments,
                  input units_segments, input minus_dot, output ready);
endinterface

### src/qcss_display.sv
// Two-digit seven-segment decode of a signed count.
`timescale 1ns / 1ps

module qcss_display (
  input  qcss_pkg::count_t count,
  output qcss_pkg::disp_t  disp
);
  import qcss_pkg::*;

  logic [COUNT_W-2:0] mag;
  logic [COUNT_W-1:0] mag_neg;
  logic [14:0]        tens_prod;
  digit_t             tens;
  logic [COUNT_W-2:0] tens_x10;
  digit_t             units;

  // Magnitude of the count; it never exceeds 99, so seven bits hold it.
  assign mag_neg = COUNT_W'(-count);
  assign mag     = count[COUNT_W-1] ? mag_neg[COUNT_W-2:0] : count[COUNT_W-2:0];

  // Divide by ten through the reciprocal 205/2048, exact for values below one thousand.
  assign tens_prod = 15'(mag) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = (COUNT_W-1)'({tens, 3'b000}) + (COUNT_W-1)'({tens, 1'b0});
  assign units     = DIGIT_W'(mag - tens_x10);

  // Segment patterns and the minus dot.
  assign disp.tens  = digit_segments(tens);
  assign disp.units = digit_segments(units);
  assign disp.minus = count[COUNT_W-1];

endmodule

### src/quadrature_counter_seven_segment.sv
// Top level of the quadrature encoder counter with two-digit seven-segment output.
//
// in_ch carries one sample word per cycle: encoder lines A and B, the active-low
// button and a one-millisecond tick. A rising edge of A counts up when B is low
// and down when B is high, saturating at plus or minus COUNT_LIMIT. A button
// press clears the count when more than lockout_ms milliseconds have passed
// since the last accepted press. cfg_we with cfg_wdata writes lockout_ms.
// out_ch delivers one result word per sample word: the count, the tens and
// units segment patterns of its magnitude and the minus dot.
// A valid result appears in the cycle after acceptance; a new word is taken
// every cycle. The edge, count and decode logic sits between the state
// registers and the result register. in_ch.ready stays high while the result
// register is empty or being drained in the same cycle, so a stalled receiver
// holds the result and back-pressures the sample channel.
// Reset clears the count, the last A sample, the millisecond counter and the
// result valid flag, and sets lockout_ms to 50.
`timescale 1ns / 1ps

module quadrature_counter_seven_segment #(
  parameter int COUNT_LIMIT = qcss_pkg::COUNT_LIMIT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  qcss_in_if.sink              in_ch,
  qcss_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  qcss_pkg::ms_t        cfg_wdata
);
  import qcss_pkg::*;

  localparam count_t LIMIT_POS = COUNT_W'(COUNT_LIMIT);
  localparam count_t LIMIT_NEG = COUNT_W'(-COUNT_LIMIT);

  ms_t    lockout_ms;
  logic   last_a;
  count_t count_reg;
  ms_t    elapsed_ms;

  logic   in_accept;
  ms_t    elapsed_tick;
  logic   a_rise;
  count_t count_step;
  logic   press;
  count_t count_next;
  ms_t    elapsed_next;
  disp_t  disp_next;

  // Handshake: take a word whenever the result register is free or drains now.
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Lockout register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms <= LOCKOUT_RESET;
    end else if (cfg_we) begin
      lockout_ms <= cfg_wdata;
    end
  end

  // Millisecond tick first, saturating at the top of the counter.
  assign elapsed_tick = (in_ch.ms_tick && elapsed_ms != ELAPSED_MAX) ?
                        elapsed_ms + 8'd1 : elapsed_ms;

  // Step on a rising edge of A, direction from B, held at the limits.
  assign a_rise = in_ch.enc_a && !last_a;
  always_comb begin
    count_step = count_reg;
    if (a_rise) begin
      if (!in_ch.enc_b) begin
        if (count_reg < LIMIT_POS) begin
          count_step = count_reg + 8'sd1;
        end
      end else begin
        if (count_reg > LIMIT_NEG) begin
          count_step = count_reg - 8'sd1;
        end
      end
    end
  end

  // An accepted press overrides a step in the same word.
  assign press        = !in_ch.button_n && (elapsed_tick > lockout_ms);
  assign count_next   = press ? '0 : count_step;
  assign elapsed_next = press ? '0 : elapsed_tick;

  qcss_display u_display (
    .count (count_next),
    .disp  (disp_next)
  );

  // Counter state, advanced once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_a     <= 1'b0;
      count_reg  <= '0;
      elapsed_ms <= '0;
    end else if (in_accept) begin
      last_a     <= in_ch.enc_a;
      count_reg  <= count_next;
      elapsed_ms <= elapsed_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_ch.count          <= count_next;
      out_ch.tens_segments  <= disp_next.tens;
      out_ch.units_segments <= disp_next.units;
      out_ch.minus_dot      <= disp_next.minus;
    end
  end

  // A held result always shows the current count state.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.count == count_reg)
    else $error("result count differs from count state");

  // The count stays inside the saturation limits.
  assert property (@(posedge clk) disable iff (rst)
    count_reg <= LIMIT_POS && count_reg >= LIMIT_NEG)
    else $error("count outside its limits");

  // Every accepted word leaves a result behind.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_ch.valid)
    else $error("accepted word produced no result");

  // The millisecond counter only holds, steps by one or clears.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (elapsed_ms == '0 || elapsed_ms == $past(elapsed_ms) ||
                     elapsed_ms == $past(elapsed_ms) + 8'd1))
    else $error("millisecond counter jumped");

endmodule
